/* design/arxpm_pkg.sv */
// Shared types and constants for the ARX plant model filter.
package arxpm_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int COEF_W    = 16;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int ACC_W     = 56;
   localparam int FRAC_SHIFT = 14;
   localparam int Q_W       = ACC_W - FRAC_SHIFT;
   localparam int DELAY_W   = 7;
   localparam int COUNT_W   = 4;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 16;
   localparam int COEF_SLOTS = 8;

   localparam logic [ACC_W-1:0]   ROUND_BIAS   = ACC_W'(8192);
   localparam logic [COEF_W-1:0]  COEF_B0_RESET = 16'd8192;

   localparam logic [CSR_IDX_W-1:0] REG_COUNT_B     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT_A     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_DELAY = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_INDEX  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_VALUE  = 4'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic op_valid;
      logic negate;
   } mac_ctl_type;

   typedef struct packed {
      logic clear;
      logic wr_en;
      logic rd_en;
      logic advance;
   } hist_ctl_type;

endpackage

/* design/arx_plant_model_filter_top.sv */
// Top level of the ARX plant model filter: sequencer, registers and output stage.
//
// Each word on the req_ channel carries one plant input sample in signed Q16.16.
// The block answers with exactly one word on the rsp_ channel: the model output
// in signed Q16.16, saturated to 32 bits, with rsp_saturated set when it clipped.
// The output is the weighted sum of delayed inputs minus the weighted sum of past
// outputs, rounded half up from the exact 56-bit sum.
// One shared multiplier and accumulator handles every term in turn (counts limited
// to MAX_TERMS): a word passes through the issue, drain and finish states before
// its result is loaded, and a new word is taken only once the sequencer is back
// in idle after its finish state; that sequence of terms through
// the single multiply-accumulate unit sets the rate. req_stall is high while a
// word is being worked on. The result waits in an output register, so a new word
// is accepted while the previous result is still held; if the receiver stalls
// for longer, the finished result waits in the sequencer until the register is
// free. Reset restores the register defaults and empties both histories at once;
// any configuration write also empties both histories but keeps coefficients.
// The user must write configuration only while idle; the block does not enforce it.
module arx_plant_model_filter_top import arxpm_pkg::*; #(
   parameter int HISTORY_DEPTH = 128,
   parameter int MAX_TERMS     = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_plant_input,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]  rsp_plant_output,
   output logic                        rsp_saturated,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DAT_W-1:0]        csr_wdata
);

   localparam int TW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int KW = $clog2(2 * MAX_TERMS + 1);
   localparam int DW = $clog2((1 << DELAY_W) + MAX_TERMS);

   // Configuration registers.
   logic [COUNT_W-1:0]       count_b_ff;
   logic [COUNT_W-1:0]       count_a_ff;
   logic [DELAY_W-1:0]       input_delay_ff;
   logic [COUNT_W-1:0]       coef_index_ff;
   logic signed [COEF_W-1:0] input_coefs_ff    [MAX_TERMS];
   logic signed [COEF_W-1:0] feedback_coefs_ff [MAX_TERMS];
   logic signed [SAMPLE_W-1:0] out_hist_ff     [MAX_TERMS];

   // Sequencer.
   state_type   state_ff, state_in;
   logic [KW-1:0] term_ff, term_in;
   logic [KW-1:0] num_b;
   logic [KW-1:0] num_a;
   logic [KW-1:0] num_total;
   logic [KW-1:0] fb_term;
   logic          cfg_write;
   logic          accept;
   logic          issue;
   logic          out_free;
   logic          finish_load;

   // Term operand registers feeding the shared unit.
   logic                       term_valid_ff;
   logic                       term_fb_ff;
   logic signed [COEF_W-1:0]   term_coef_ff;
   logic signed [SAMPLE_W-1:0] term_fb_sample_ff;
   logic signed [SAMPLE_W-1:0] mac_sample;

   // Output stage.
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_output_ff;
   logic                       rsp_sat_ff;

   hist_ctl_type               hist_ctl;
   mac_ctl_type                mac_ctl;
   logic [DW-1:0]              rd_delay;
   logic signed [SAMPLE_W-1:0] hist_data;
   logic                       hist_live;
   logic signed [ACC_W-1:0]    acc;
   logic [ACC_W-1:0]           acc_rounded;
   logic [Q_W-1:0]             q_val;
   logic                       sat_hi;
   logic                       sat_lo;
   logic signed [SAMPLE_W-1:0] y_val;

   assign cfg_write = csr_we && (csr_index <= REG_COEF_VALUE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Counts above the storage are used as the storage size.
   assign num_b     = (32'(count_b_ff) > MAX_TERMS) ? KW'(MAX_TERMS) : KW'(count_b_ff);
   assign num_a     = (32'(count_a_ff) > MAX_TERMS) ? KW'(MAX_TERMS) : KW'(count_a_ff);
   assign num_total = num_b + num_a;
   assign fb_term   = term_ff - num_b;
   assign rd_delay  = DW'(input_delay_ff) + DW'(term_ff[TW-1:0]);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_b_ff     <= COUNT_W'(1);
         count_a_ff     <= COUNT_W'(1);
         input_delay_ff <= DELAY_W'(1);
         coef_index_ff  <= '0;
         for (int s = 0; s < MAX_TERMS; s++) begin
            input_coefs_ff[s]    <= (s == 0) ? COEF_B0_RESET : '0;
            feedback_coefs_ff[s] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            REG_COUNT_B: begin
               count_b_ff <= csr_wdata[COUNT_W-1:0];
            end
            REG_COUNT_A: begin
               count_a_ff <= csr_wdata[COUNT_W-1:0];
            end
            REG_INPUT_DELAY: begin
               input_delay_ff <= csr_wdata[DELAY_W-1:0];
            end
            REG_COEF_INDEX: begin
               coef_index_ff <= csr_wdata[COUNT_W-1:0];
            end
            REG_COEF_VALUE: begin
               // Slots that have no storage are silently dropped.
               for (int s = 0; s < MAX_TERMS; s++) begin
                  if (s < COEF_SLOTS) begin
                     if (32'(coef_index_ff) == s) begin
                        input_coefs_ff[s] <= csr_wdata;
                     end
                     if (32'(coef_index_ff) == s + COEF_SLOTS) begin
                        feedback_coefs_ff[s] <= csr_wdata;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ISSUE;
               term_in  = '0;
            end
         end
         ST_ISSUE: begin
            if (term_ff < num_total) begin
               term_in = term_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output logic of the sequencer.
   always_comb begin
      req_stall        = 1'b1;
      issue            = 1'b0;
      finish_load      = 1'b0;
      hist_ctl         = '0;
      mac_ctl          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall      = 1'b0;
            hist_ctl.wr_en = accept;
            mac_ctl.clear  = accept;
         end
         ST_ISSUE: begin
            issue          = term_ff < num_total;
            hist_ctl.rd_en = issue && (term_ff < num_b);
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            finish_load      = out_free;
            hist_ctl.advance = out_free;
         end
         default: begin
         end
      endcase
      hist_ctl.clear   = cfg_write;
      mac_ctl.op_valid = term_valid_ff;
      mac_ctl.negate   = term_fb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

   // Stage 0: fetch coefficient and, for feedback terms, the past output.
   always_ff @(posedge clock) begin
      if (reset) begin
         term_valid_ff <= 1'b0;
      end else begin
         term_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         if (term_ff < num_b) begin
            term_fb_ff   <= 1'b0;
            term_coef_ff <= input_coefs_ff[term_ff[TW-1:0]];
         end else begin
            term_fb_ff        <= 1'b1;
            term_coef_ff      <= feedback_coefs_ff[fb_term[TW-1:0]];
            term_fb_sample_ff <= out_hist_ff[fb_term[TW-1:0]];
         end
      end
   end

   // Input terms that reach past the written history count as zero.
   assign mac_sample = term_fb_ff ? term_fb_sample_ff :
                       (hist_live ? hist_data : '0);

   arxpm_hist #(
      .DEPTH   (HISTORY_DEPTH),
      .DELAY_W (DW)
   ) u_hist (
      .clock    (clock),
      .reset    (reset),
      .ctl      (hist_ctl),
      .wr_data  (req_plant_input),
      .rd_delay (rd_delay),
      .rd_data  (hist_data),
      .rd_live  (hist_live)
   );

   arxpm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .sample (mac_sample),
      .coef   (term_coef_ff),
      .acc    (acc)
   );

   // Round half up to Q16.16, then clip to the 32-bit range.
   always_comb begin
      acc_rounded = acc + ROUND_BIAS;
      q_val       = acc_rounded[ACC_W-1:FRAC_SHIFT];
      sat_hi      = !q_val[Q_W-1] && (|q_val[Q_W-2:SAMPLE_W-1]);
      sat_lo      = q_val[Q_W-1] && !(&q_val[Q_W-2:SAMPLE_W-1]);
      if (sat_hi) begin
         y_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (sat_lo) begin
         y_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         y_val = q_val[SAMPLE_W-1:0];
      end
   end

   // Output history: entry i is the output i+1 samples back.
   always_ff @(posedge clock) begin
      if (reset || cfg_write) begin
         for (int s = 0; s < MAX_TERMS; s++) begin
            out_hist_ff[s] <= '0;
         end
      end else if (finish_load) begin
         out_hist_ff[0] <= y_val;
         for (int s = 1; s < MAX_TERMS; s++) begin
            out_hist_ff[s] <= out_hist_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_load) begin
         rsp_output_ff <= y_val;
         rsp_sat_ff    <= sat_hi || sat_lo;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_plant_output = rsp_output_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

/* design/arxpm_mac.sv */
// Shared pipelined multiply-accumulate unit: product register, then accumulator.
module arxpm_mac import arxpm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  mac_ctl_type                ctl,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic signed [COEF_W-1:0]   coef,
   output logic signed [ACC_W-1:0]    acc
);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_valid_ff;
   logic                     prod_neg_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  prod_ext;

   always_ff @(posedge clock) begin
      prod_ff     <= sample * coef;
      prod_neg_ff <= ctl.negate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.op_valid;
      end
   end

   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         if (prod_neg_ff) begin
            acc_ff <= acc_ff - prod_ext;
         end else begin
            acc_ff <= acc_ff + prod_ext;
         end
      end
   end

   assign acc = acc_ff;

endmodule

/* design/arxpm_hist.sv */
// Input sample history: a circular memory with write pointer and fill count.
module arxpm_hist import arxpm_pkg::*; #(
   parameter int DEPTH   = 128,
   parameter int DELAY_W = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hist_ctl_type               ctl,
   input  logic signed [SAMPLE_W-1:0] wr_data,
   input  logic [DELAY_W-1:0]         rd_delay,
   output logic signed [SAMPLE_W-1:0] rd_data,
   output logic                       rd_live
);

   localparam int PW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = ((DELAY_W > FW) ? DELAY_W : FW) + 1;

   logic signed [SAMPLE_W-1:0] mem [DEPTH];
   logic [PW-1:0]              wp_ff;
   logic [FW-1:0]              fill_ff;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       rd_live_ff;
   logic [CW-1:0]              base;
   logic [CW-1:0]              span;
   logic [CW-1:0]              diff;
   logic                       live;
   logic [PW-1:0]              rd_addr;

   // An entry is meaningful only if it was written since the last clear.
   always_comb begin
      base = CW'(wp_ff);
      span = CW'(rd_delay);
      live = span < CW'(fill_ff);
      diff = base - span;
      if (base < span) begin
         diff = diff + CW'(DEPTH);
      end
      rd_addr = live ? diff[PW-1:0] : wp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (ctl.wr_en && (fill_ff < FW'(DEPTH))) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (ctl.advance) begin
            if (wp_ff == PW'(DEPTH - 1)) begin
               wp_ff <= '0;
            end else begin
               wp_ff <= wp_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wp_ff] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_live_ff <= live;
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_live = rd_live_ff;

endmodule

/* tb/sv/tb_arx_plant_model_filter_top.sv */
// Self-checking testbench for the ARX plant model filter: predicts every output word and checks it.
module tb_arx_plant_model_filter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import arxpm_pkg::*;

   // Sizes of the block as instantiated (default parameters).
   localparam int HISTORY_DEPTH = 128;
   localparam int MAX_TERMS     = 8;

   // Run control.
   localparam int CYCLE_LIMIT      = 300000;
   localparam int SETTLE_CYCLES    = 24;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_WORDS     = 600;

   localparam longint SAMPLE_MAX = (longint'(1) << 31) - 1;
   localparam longint SAMPLE_MIN = -(longint'(1) << 31);

   // One expected output word: the model sample and whether it was clipped.
   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                clipped;
   } plant_output_type;

   // Keeps its own copy of the registers and both histories, works out the output
   // word that each accepted input word must produce and checks the words that arrive.
   class plant_output_tracker;
      logic [COUNT_W-1:0]         count_b;
      logic [COUNT_W-1:0]         count_a;
      logic [DELAY_W-1:0]         input_delay;
      logic [CSR_IDX_W-1:0]       coef_index;
      logic signed [COEF_W-1:0]   input_coefs[MAX_TERMS];
      logic signed [COEF_W-1:0]   feedback_coefs[MAX_TERMS];
      logic signed [SAMPLE_W-1:0] input_history[HISTORY_DEPTH];
      logic signed [SAMPLE_W-1:0] output_history[MAX_TERMS];
      int unsigned                write_ptr;
      plant_output_type           expected_outputs[$];
      int unsigned                errors;
      int unsigned                outputs_checked;
      int unsigned                clipped_seen;

      function new();
         errors = 0;
         outputs_checked = 0;
         clipped_seen = 0;
         count_b = 1;
         count_a = 1;
         input_delay = 1;
         coef_index = 0;
         foreach (input_coefs[i]) begin
            input_coefs[i] = '0;
            feedback_coefs[i] = '0;
         end
         input_coefs[0] = COEF_B0_RESET;
         clear_histories();
      endfunction

      function void clear_histories();
         foreach (input_history[i]) input_history[i] = '0;
         foreach (output_history[i]) output_history[i] = '0;
         write_ptr = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DAT_W-1:0] data);
         int slot;
         // Unknown indexes leave everything untouched, histories included.
         if (index > REG_COEF_VALUE)
            return;
         clear_histories();
         case (index)
            REG_COUNT_B:     count_b = data[COUNT_W-1:0];
            REG_COUNT_A:     count_a = data[COUNT_W-1:0];
            REG_INPUT_DELAY: input_delay = data[DELAY_W-1:0];
            REG_COEF_INDEX:  coef_index = data[CSR_IDX_W-1:0];
            REG_COEF_VALUE: begin
               if (coef_index < COEF_SLOTS) begin
                  slot = coef_index;
                  if (slot < MAX_TERMS)
                     input_coefs[slot] = data;
               end else begin
                  slot = coef_index - COEF_SLOTS;
                  if (slot < MAX_TERMS)
                     feedback_coefs[slot] = data;
               end
            end
            default: ;
         endcase
      endfunction

      function void note_input_sample(logic signed [SAMPLE_W-1:0] sample);
         longint           acc;
         longint           rounded;
         int               terms_b;
         int               terms_a;
         int               lag;
         int               pos;
         plant_output_type result;
         terms_b = (count_b > MAX_TERMS) ? MAX_TERMS : count_b;
         terms_a = (count_a > MAX_TERMS) ? MAX_TERMS : count_a;
         input_history[write_ptr] = sample;
         acc = 0;
         for (int i = 0; i < terms_b; i++) begin
            lag = input_delay + i;
            // Terms reaching past the stored history are dropped.
            if (lag < HISTORY_DEPTH) begin
               pos = (write_ptr + HISTORY_DEPTH - lag) % HISTORY_DEPTH;
               acc += longint'(input_coefs[i]) * longint'(input_history[pos]);
            end
         end
         for (int i = 0; i < terms_a; i++)
            acc -= longint'(feedback_coefs[i]) * longint'(output_history[i]);
         // Round half up to Q16.16, then clamp to 32 bits.
         rounded = (acc + longint'(8192)) >>> FRAC_SHIFT;
         result.clipped = 1'b1;
         if (rounded > SAMPLE_MAX)
            result.value = SAMPLE_MAX[SAMPLE_W-1:0];
         else if (rounded < SAMPLE_MIN)
            result.value = SAMPLE_MIN[SAMPLE_W-1:0];
         else begin
            result.value = rounded[SAMPLE_W-1:0];
            result.clipped = 1'b0;
         end
         for (int i = MAX_TERMS - 1; i > 0; i--)
            output_history[i] = output_history[i - 1];
         output_history[0] = result.value;
         write_ptr = (write_ptr + 1) % HISTORY_DEPTH;
         expected_outputs.push_back(result);
      endfunction

      function void check_output_sample(logic [SAMPLE_W-1:0] value, logic clipped);
         plant_output_type want;
         if (expected_outputs.size() == 0) begin
            errors++;
            $display("%0t: output word %0d arrived with no input word outstanding",
                     $time, $signed(value));
            return;
         end
         want = expected_outputs.pop_front();
         outputs_checked++;
         if (want.clipped)
            clipped_seen++;
         if (value !== want.value) begin
            errors++;
            $display("%0t: plant_output mismatch: expected %0d, actual %0d",
                     $time, $signed(want.value), $signed(value));
         end
         if (clipped !== want.clipped) begin
            errors++;
            $display("%0t: saturated mismatch: expected %0b, actual %0b",
                     $time, want.clipped, clipped);
         end
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [SAMPLE_W-1:0]  req_plant_input = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0]  rsp_plant_output;
   logic                        rsp_saturated;
   logic                        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DAT_W-1:0]        csr_wdata = '0;

   plant_output_tracker tracker = new();

   // Largest idle gap either side may draw per word; zero gives a stretch with no idling.
   int unsigned max_gap = 10;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit          long_hold_due = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned words_sent = 0;
   int unsigned settings_applied = 0;

   arx_plant_model_filter_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_plant_input  (req_plant_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_plant_output (rsp_plant_output),
      .rsp_saturated    (rsp_saturated),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // The run is stopped here if it never reaches its normal end.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_arx_plant_model_filter_top: errors");
         $finish;
      end
   end

   // Offers one input word after a random gap and waits for the handshake. The
   // valid stays high on acceptance, so a following word with no gap goes straight
   // on without valid dropping in between.
   task automatic send_word(input logic signed [SAMPLE_W-1:0] sample);
      int unsigned gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_plant_input <= sample;
      do @(posedge clock); while (!(req_valid && !req_stall));
      tracker.note_input_sample(sample);
      words_sent++;
   endtask

   // Registers are only written once every outstanding output word has come back
   // and the block has had time to finish anything still in flight.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (tracker.expected_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Presents one register write; the enable is dropped by finish_writes so that it
   // stays high without a glitch across a batch of writes.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DAT_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      tracker.write_register(index, data);
      @(posedge clock);
   endtask

   task automatic set_coef(input int slot, input logic [CSR_DAT_W-1:0] value);
      write_reg(REG_COEF_INDEX, CSR_DAT_W'(slot));
      write_reg(REG_COEF_VALUE, value);
   endtask

   task automatic finish_writes();
      csr_we <= 1'b0;
      settings_applied++;
      @(posedge clock);
   endtask

   // Random upper bits above the field, which the block must ignore.
   function automatic logic [CSR_DAT_W-1:0] with_noise(input int value, input int width);
      logic [CSR_DAT_W-1:0] mask;
      mask = {CSR_DAT_W{1'b1}} << width;
      return (CSR_DAT_W'($urandom) & mask) | (CSR_DAT_W'(value) & ~mask);
   endfunction

   // Receiver: draws a stall length for every word, counted from the moment a word
   // is on offer, and takes one long hold-off when the stimulus asks for it.
   initial begin : receiver
      int unsigned hold;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (long_hold_due) begin
            hold = LONG_HOLD_CYCLES;
            long_hold_due = 1'b0;
         end else begin
            hold = $urandom_range(0, max_gap);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            do @(posedge clock); while (!rsp_valid);
            repeat (hold - 1) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         tracker.check_output_sample(rsp_plant_output, rsp_saturated);
      end
   end

   // Main stimulus: a directed opening followed by randomised register settings.
   initial begin : stimulus
      logic [SAMPLE_W-1:0]        extreme_words[5];
      logic signed [SAMPLE_W-1:0] sample;
      int                         scenario;
      int                         words;
      int                         pick;
      int                         target;
      bit                         pressure_done;

      extreme_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                        32'h0000_0001};
      pressure_done = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: half the input one sample late, no feedback. The first output
      // comes from the cleared history.
      foreach (extreme_words[i])
         send_word(extreme_words[i]);

      // Full term counts with no delay and the largest coefficients in every slot:
      // drives the sum past both ends of the 32-bit range.
      wait_until_idle();
      write_reg(REG_COUNT_B, CSR_DAT_W'(MAX_TERMS));
      write_reg(REG_COUNT_A, CSR_DAT_W'(MAX_TERMS));
      write_reg(REG_INPUT_DELAY, '0);
      for (int slot = 0; slot < 2 * COEF_SLOTS; slot++)
         set_coef(slot, (slot < COEF_SLOTS) ? 16'h7FFF : 16'h8000);
      finish_writes();
      repeat (3) send_word(32'sh7FFF_FFFF);
      repeat (3) send_word(32'sh8000_0000);

      // Counts above the number of stored terms, the longest delay so that most input
      // terms fall off the end of the history, and a write to an unknown index.
      wait_until_idle();
      write_reg(REG_COUNT_B, 16'hFFFF);
      write_reg(REG_COUNT_A, 16'hFFFC);
      write_reg(REG_INPUT_DELAY, 16'hFFFF);
      write_reg(CSR_IDX_W'(REG_COEF_VALUE + 1), 16'h1234);
      set_coef(2 * COEF_SLOTS - 1, 16'h8000);
      set_coef(0, 16'h7FFF);
      finish_writes();
      send_word(32'sh7FFF_FFFF);
      send_word(32'sh8000_0000);
      send_word(32'sh0000_0001);
      send_word(-32'sd1);
      send_word($urandom);

      // No terms at all: the output is zero whatever comes in.
      wait_until_idle();
      write_reg(REG_COUNT_B, '0);
      write_reg(REG_COUNT_A, '0);
      finish_writes();
      repeat (3) send_word($urandom);

      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         scenario = $urandom_range(0, 3);
         wait_until_idle();
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
         case (scenario)
            0: begin
               // Well-behaved model: short delay, mild feedback that stays stable.
               write_reg(REG_COUNT_B, with_noise($urandom_range(1, MAX_TERMS), COUNT_W));
               write_reg(REG_COUNT_A, with_noise($urandom_range(0, 3), COUNT_W));
               write_reg(REG_INPUT_DELAY, with_noise($urandom_range(0, 8), DELAY_W));
               for (int slot = 0; slot < MAX_TERMS; slot++)
                  set_coef(slot, CSR_DAT_W'(int'($urandom_range(0, 32767)) - 16384));
               for (int slot = 0; slot < 3; slot++)
                  set_coef(COEF_SLOTS + slot,
                           CSR_DAT_W'(int'($urandom_range(0, 8192)) - 4096));
               words = $urandom_range(20, 60);
            end
            1: begin
               // Anything the registers allow, including over-range counts.
               write_reg(REG_COUNT_B, with_noise($urandom_range(0, 15), COUNT_W));
               write_reg(REG_COUNT_A, with_noise($urandom_range(0, 15), COUNT_W));
               write_reg(REG_INPUT_DELAY, with_noise($urandom_range(0, 127), DELAY_W));
               repeat (4)
                  set_coef($urandom_range(0, 2 * COEF_SLOTS - 1), CSR_DAT_W'($urandom));
               if ($urandom_range(0, 1) == 1)
                  write_reg(CSR_IDX_W'($urandom_range(int'(REG_COEF_VALUE) + 1, 15)),
                            CSR_DAT_W'($urandom));
               words = $urandom_range(20, 60);
            end
            2: begin
               // Long transport delay: enough words to wrap the input history, with
               // the later terms partly dropped.
               write_reg(REG_COUNT_B, with_noise(MAX_TERMS, COUNT_W));
               write_reg(REG_COUNT_A, with_noise($urandom_range(0, 2), COUNT_W));
               write_reg(REG_INPUT_DELAY, with_noise($urandom_range(100, 127), DELAY_W));
               for (int slot = 0; slot < MAX_TERMS; slot++)
                  set_coef(slot, CSR_DAT_W'($urandom));
               for (int slot = 0; slot < 2; slot++)
                  set_coef(COEF_SLOTS + slot,
                           CSR_DAT_W'(int'($urandom_range(0, 8192)) - 4096));
               words = $urandom_range(150, 200);
            end
            default: begin
               // Extreme coefficients and full-range samples: frequent clipping.
               write_reg(REG_COUNT_B, with_noise(MAX_TERMS, COUNT_W));
               write_reg(REG_COUNT_A, with_noise(MAX_TERMS, COUNT_W));
               write_reg(REG_INPUT_DELAY, with_noise($urandom_range(0, 3), DELAY_W));
               for (int slot = 0; slot < 2 * COEF_SLOTS; slot++)
                  set_coef(slot, ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000);
               words = $urandom_range(10, 30);
            end
         endcase
         finish_writes();

         // Once, well into the run, the receiver holds off for a long time while the
         // sender keeps offering words, so the block fills and stalls its input.
         if (!pressure_done && words_sent > 200) begin
            long_hold_due = 1'b1;
            pressure_done = 1'b1;
         end

         repeat (words) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               sample = extreme_words[$urandom_range(0, 4)];
            else if (pick < 4 || scenario == 3)
               sample = $urandom;
            else
               sample = int'($urandom_range(0, 2097152)) - 1048576;
            send_word(sample);
         end
      end

      // Drain: every outstanding word must come back, then a quiet spell to catch
      // anything unexpected.
      wait_until_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d input words and %0d checked output words (%0d clipped)",
               words_sent, tracker.outputs_checked, tracker.clipped_seen);
      $display("over %0d register settings in %0d cycles, including one long receiver hold-off.",
               settings_applied, cycle_count);
      if (tracker.errors == 0 && tracker.expected_outputs.size() == 0) begin
         $display("tb_arx_plant_model_filter_top: clean");
      end else begin
         $display("tb_arx_plant_model_filter_top: errors");
      end
      $finish;
   end

endmodule
